@@ sv/bst_pkg.sv @@
// ----------------------------------------------------------------------------
// Bone skinning vertex transform package
// Shared types, constants and fixed-point helpers for the skinning block.
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam int XY_W       = 32;   // Q16.16 coordinate and coefficient width
    localparam int WEIGHT_W   = 17;   // Q1.16 weight, 65536 is one
    localparam int BONE_IDX_W = 5;    // one packed bone number
    localparam int MAX_INF    = 4;    // influences carried per vertex
    localparam int INF_IDX_W  = 2;    // selects one of MAX_INF influences
    localparam int COEFS      = 6;    // coefficients per affine matrix
    localparam int LANE_W     = 3;    // selects one of COEFS coefficients
    localparam int ADDR_W     = 8;    // table address width
    localparam int ROW_FULL_W = 6;    // table address divided by COEFS
    localparam int CFG_IDX_W  = 3;
    localparam int QDEPTH     = 2;    // entries between front and back
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    // Division by six of an 8-bit address: (addr * 171) >> 10 is exact below 256.
    localparam int RECIP6       = 171;
    localparam int RECIP6_SHIFT = 10;
    localparam int RECIP6_W     = 16;

    localparam int PROD_W  = 48;      // 32x32 product with its low 16 bits dropped
    localparam int BPROD_W = 34;      // 32x18 product with its low 16 bits dropped
    localparam int ACC_W   = 36;      // sum of up to four blend products
    localparam int SUM_W   = 50;      // two products plus a translation

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORLD_M0    = 3'd0,
        REG_WORLD_M1    = 3'd1,
        REG_WORLD_M2    = 3'd2,
        REG_WORLD_M3    = 3'd3,
        REG_WORLD_TX    = 3'd4,
        REG_WORLD_TY    = 3'd5,
        REG_SKIN_ENABLE = 3'd6
    } bst_reg_idx_t;

    typedef struct packed {
        logic [COEFS-1:0][XY_W-1:0] m;     // m0, m1, m2, m3, tx, ty
        logic                       skin;
    } bst_cfg_t;

    // One classified transaction waiting for the execution side.
    typedef struct packed {
        logic                                  is_vertex;
        logic [XY_W-1:0]                       pos_x;
        logic [XY_W-1:0]                       pos_y;
        logic [MAX_INF-1:0][BONE_IDX_W-1:0]    bone;
        logic [MAX_INF-1:0][WEIGHT_W-1:0]      weight;
        logic                                  wr_ok;
        logic [ROW_FULL_W-1:0]                 wr_row;
        logic [LANE_W-1:0]                     wr_lane;
        logic [XY_W-1:0]                       wr_value;
    } bst_item_t;

    // Saturate a wide signed sum to 32 bits.
    function automatic logic [XY_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [XY_W-1:0] r;
        if ((&v[SUM_W-1:XY_W-1]) || !(|v[SUM_W-1:XY_W-1]))
        begin
            r = v[XY_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            r = {1'b1, {(XY_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(XY_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

@@ sv/bst_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/bst_front.sv @@
// ----------------------------------------------------------------------------
// Skinning front end
// Accepts transactions, decodes table addresses and queues classified items.
// ----------------------------------------------------------------------------
module bst_front #(
    parameter int BONE_COUNT = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        operation,
    input  logic [31:0]                 pos_x,
    input  logic [31:0]                 pos_y,
    input  logic [19:0]                 bone_indices,
    input  logic [16:0]                 weight_0,
    input  logic [16:0]                 weight_1,
    input  logic [16:0]                 weight_2,
    input  logic [16:0]                 weight_3,
    input  logic [7:0]                  table_address,
    input  logic [31:0]                 table_value,
    output logic                        q_vld,
    output bst_pkg::bst_item_t          q_item,
    input  logic                        q_pop
);

    import bst_pkg::*;

    localparam logic [ADDR_W:0] TABLE_LIMIT = (ADDR_W+1)'(BONE_COUNT * COEFS);

    bst_item_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg, count_next;
    bst_item_t             new_item;
    logic [RECIP6_W-1:0]   recip_prod;
    logic [ROW_FULL_W-1:0] row;
    logic [ADDR_W-1:0]     lane_full;
    logic                  push;

    // Table address split into bone row and coefficient lane.
    assign recip_prod = {{(RECIP6_W-ADDR_W){1'b0}}, table_address} * RECIP6_W'(RECIP6);
    assign row        = recip_prod[RECIP6_SHIFT +: ROW_FULL_W];
    assign lane_full  = table_address - ADDR_W'({2'b00, row} * ADDR_W'(COEFS));

    always_comb
    begin
        new_item.is_vertex = operation;
        new_item.pos_x     = pos_x;
        new_item.pos_y     = pos_y;
        for (int i = 0; i < MAX_INF; i++)
        begin
            new_item.bone[i] = bone_indices[i*BONE_IDX_W +: BONE_IDX_W];
        end
        new_item.weight[0] = weight_0;
        new_item.weight[1] = weight_1;
        new_item.weight[2] = weight_2;
        new_item.weight[3] = weight_3;
        new_item.wr_ok     = ({1'b0, table_address} < TABLE_LIMIT);
        new_item.wr_row    = row;
        new_item.wr_lane   = lane_full[LANE_W-1:0];
        new_item.wr_value  = table_value;
    end

    assign in_ready = (count_reg != QCNT_W'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_vld    = (count_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

@@ sv/bst_back.sv @@
// ----------------------------------------------------------------------------
// Skinning execution back end
// Performs table writes, and per vertex the world transform and optional bone blend.
// ----------------------------------------------------------------------------
module bst_back #(
    parameter int BONE_COUNT = 32,
    parameter int INFLUENCES = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bst_pkg::bst_cfg_t  cfg,
    input  logic               q_vld,
    input  bst_pkg::bst_item_t q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        out_x,
    output logic [31:0]        out_y
);

    import bst_pkg::*;

    localparam int ROW_W = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;
    localparam logic [BONE_IDX_W:0]  BONE_LIMIT = (BONE_IDX_W+1)'(BONE_COUNT);
    localparam logic [INF_IDX_W-1:0] INF_LAST   = INF_IDX_W'(INFLUENCES - 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_WSUM  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_BMUL  = 6'b010000,
        ST_BSUM  = 6'b100000
    } bk_state_t;

    bk_state_t state_reg, state_next;
    logic [INF_IDX_W-1:0] cnt_reg, cnt_next;

    logic [MAX_INF-1:0][BONE_IDX_W-1:0] cur_bone_reg;
    logic [MAX_INF-1:0][WEIGHT_W-1:0]   cur_weight_reg;

    logic signed [PROD_W-1:0]  prod_reg [4];
    logic signed [XY_W-1:0]    wx_reg, wy_reg;
    logic                      rd_vld_reg;
    logic                      rd_ok_reg;
    logic [WEIGHT_W-1:0]       rd_w_reg;
    logic                      bp_vld_reg;
    logic signed [BPROD_W-1:0] bprod_reg [COEFS];
    logic signed [ACC_W-1:0]   acc_reg [COEFS];
    logic                      out_vld_reg;
    logic [XY_W-1:0]           out_x_reg, out_y_reg;

    logic                      start;
    logic                      out_free;
    logic                      ram_re;
    logic [ROW_W-1:0]          ram_raddr;
    logic [COEFS-1:0]          ram_we;
    logic [XY_W-1:0]           ram_rdata [COEFS];
    logic signed [XY_W-1:0]    blend_sat [COEFS];
    logic signed [XY_W-1:0]    ma [4];
    logic signed [XY_W-1:0]    mbx, mby;
    logic signed [2*XY_W-1:0]  mp [4];
    logic signed [XY_W-1:0]    tx, ty;
    logic signed [SUM_W-1:0]   sum_x, sum_y;
    logic [XY_W-1:0]           res_x, res_y;
    logic signed [49:0]        bmul [COEFS];

    assign out_free = !out_vld_reg || out_ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_vld;
    assign start    = q_pop && q_item.is_vertex;

    // Coefficient table: one RAM per coefficient so a whole bone reads at once.
    assign ram_re    = (state_reg == ST_READ);
    assign ram_raddr = cur_bone_reg[cnt_reg][ROW_W-1:0];

    for (genvar j = 0; j < COEFS; j++)
    begin : g_lane
        assign ram_we[j] = q_pop && !q_item.is_vertex && q_item.wr_ok
                           && (q_item.wr_lane == LANE_W'(j));

        bst_ram #(
            .WIDTH (XY_W),
            .DEPTH (BONE_COUNT)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[j]),
            .waddr (q_item.wr_row[ROW_W-1:0]),
            .wdata (q_item.wr_value),
            .re    (ram_re),
            .raddr (ram_raddr),
            .rdata (ram_rdata[j])
        );

        assign bmul[j]      = $signed(ram_rdata[j]) * $signed({1'b0, rd_w_reg});
        assign blend_sat[j] = $signed(sat32(SUM_W'(acc_reg[j])));
    end

    // Shared 2x2 matrix multiplier: world matrix at vertex start, blend matrix later.
    always_comb
    begin
        if (state_reg == ST_BMUL)
        begin
            for (int k = 0; k < 4; k++)
            begin
                ma[k] = blend_sat[k];
            end
            mbx = wx_reg;
            mby = wy_reg;
        end
        else
        begin
            for (int k = 0; k < 4; k++)
            begin
                ma[k] = $signed(cfg.m[k]);
            end
            mbx = $signed(q_item.pos_x);
            mby = $signed(q_item.pos_y);
        end
        mp[0] = ma[0] * mbx;
        mp[1] = ma[2] * mby;
        mp[2] = ma[1] * mbx;
        mp[3] = ma[3] * mby;
    end

    // Sum of two truncated products and the translation.
    always_comb
    begin
        if (state_reg == ST_BSUM)
        begin
            tx = blend_sat[4];
            ty = blend_sat[5];
        end
        else
        begin
            tx = $signed(cfg.m[4]);
            ty = $signed(cfg.m[5]);
        end
        sum_x = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(tx);
        sum_y = SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]) + SUM_W'(ty);
        res_x = sat32(sum_x);
        res_y = sat32(sum_y);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_WSUM;
                    cnt_next   = '0;
                end
            end
            ST_WSUM:
            begin
                if (cfg.skin)
                begin
                    state_next = ST_READ;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (cnt_reg == INF_LAST)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // Drains RAM data into the products, then products into the accumulators.
                if (cnt_reg[0])
                begin
                    state_next = ST_BMUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_BMUL:
            begin
                state_next = ST_BSUM;
            end
            ST_BSUM:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            bp_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= ram_re;
            bp_vld_reg <= rd_vld_reg;
            if (((state_reg == ST_WSUM) && !cfg.skin || (state_reg == ST_BSUM)) && out_free)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_bone_reg   <= q_item.bone;
            cur_weight_reg <= q_item.weight;
        end
        if (start || (state_reg == ST_BMUL))
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= mp[k][2*XY_W-1:16];
            end
        end
        if (state_reg == ST_WSUM)
        begin
            wx_reg <= $signed(res_x);
            wy_reg <= $signed(res_y);
        end
        if (ram_re)
        begin
            rd_w_reg  <= cur_weight_reg[cnt_reg];
            rd_ok_reg <= ({1'b0, cur_bone_reg[cnt_reg]} < BONE_LIMIT);
        end
        for (int j = 0; j < COEFS; j++)
        begin
            bprod_reg[j] <= rd_ok_reg ? bmul[j][49:16] : '0;
            if (start)
            begin
                acc_reg[j] <= '0;
            end
            else if (bp_vld_reg)
            begin
                acc_reg[j] <= acc_reg[j] + ACC_W'(bprod_reg[j]);
            end
        end
        if (((state_reg == ST_WSUM) && !cfg.skin || (state_reg == ST_BSUM)) && out_free)
        begin
            out_x_reg <= res_x;
            out_y_reg <= res_y;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;

`ifndef ASSERT_OFF
    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_vld)
        else $error("queue popped while empty");

    a_blend_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BMUL) |-> (!rd_vld_reg && !bp_vld_reg))
        else $error("blend multiply started before accumulation finished");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == ST_WSUM || state_reg == ST_BSUM))
        else $error("result produced outside a sum state");

    a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_re && (|ram_we)))
        else $error("coefficient table read and written in one cycle");
`endif

endmodule

@@ sv/bone_skinning_vertex_transform.sv @@
// ----------------------------------------------------------------------------
// Bone skinning vertex transform
// 2D world affine transform followed by four-bone linear blend skinning.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                      Direction
//  --------  -------------------------------------------  ---------
//  input     in_valid/in_ready, operation, pos_x, pos_y,  in
//            bone_indices, weight_0..3, table_address,
//            table_value
//  output    out_valid/out_ready, out_x, out_y            out
//  config    cfg_write, cfg_index, cfg_data               in
//
//  A table write transaction completes as it is popped in the idle state.
//  A vertex runs the world sum and, with skinning on, the bone reads, the
//  drain, the blend multiply on the shared multiplier and the blend sum;
//  the six coefficient RAMs give one bone per cycle through a single read port.
//  Reset clears the queue, sequencer and output valid and restores the world
//  registers to identity with skinning off; the bone table is not cleared.
//  A two-entry queue lets the input keep accepting while a result waits.
//
module bone_skinning_vertex_transform #(
    parameter int BONE_COUNT = 32,
    parameter int INFLUENCES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [19:0] bone_indices,
    input  logic [16:0] weight_0,
    input  logic [16:0] weight_1,
    input  logic [16:0] weight_2,
    input  logic [16:0] weight_3,
    input  logic [7:0]  table_address,
    input  logic [31:0] table_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    import bst_pkg::*;

    bst_cfg_t  cfg_reg;
    logic      q_vld;
    logic      q_pop;
    bst_item_t q_item;

    // Configuration registers. The user must write them only while the block
    // is idle (not enforced), so execution sees them static per transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.m    <= {32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd65536};
            cfg_reg.skin <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (bst_reg_idx_t'(cfg_index))
                REG_WORLD_M0:    cfg_reg.m[0] <= cfg_data;
                REG_WORLD_M1:    cfg_reg.m[1] <= cfg_data;
                REG_WORLD_M2:    cfg_reg.m[2] <= cfg_data;
                REG_WORLD_M3:    cfg_reg.m[3] <= cfg_data;
                REG_WORLD_TX:    cfg_reg.m[4] <= cfg_data;
                REG_WORLD_TY:    cfg_reg.m[5] <= cfg_data;
                REG_SKIN_ENABLE: cfg_reg.skin <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // The front decodes each transaction and queues it.
    bst_front #(
        .BONE_COUNT (BONE_COUNT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .bone_indices  (bone_indices),
        .weight_0      (weight_0),
        .weight_1      (weight_1),
        .weight_2      (weight_2),
        .weight_3      (weight_3),
        .table_address (table_address),
        .table_value   (table_value),
        .q_vld         (q_vld),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    // The back owns the bone table and the arithmetic, in queue order, so a
    // table write is always visible to every vertex that follows it.
    bst_back #(
        .BONE_COUNT (BONE_COUNT),
        .INFLUENCES (INFLUENCES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_vld     (q_vld),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y)
    );

endmodule
